/* hdl/sma_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor moving average package
// Shared sizes, sequencer states and the window clamp for the averaging core.
// ----------------------------------------------------------------------------
package sma_pkg;

  localparam int RING_DEPTH = 64;
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = IDX_W + 1;          // holds RING_DEPTH itself
  localparam int WIN_W      = 7;                  // width of window_length register
  localparam int CODE_W     = 16;
  localparam int SUM_W      = CODE_W + IDX_W;     // exact sum over the full ring
  localparam int DIV_STEP_W = $clog2(SUM_W + 1);  // divider step counter width
  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(16);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_SUM,
    ST_DIV,
    ST_EMIT
  } sma_state_e;

  // Clamp the configured window to 1 .. RING_DEPTH.
  function automatic logic [CNT_W-1:0] eff_window(input logic [WIN_W-1:0] w);
    logic [CNT_W-1:0] r;
    if (w == '0) begin
      r = CNT_W'(1);
    end else if (int'(w) > RING_DEPTH) begin
      r = CNT_W'(RING_DEPTH);
    end else begin
      r = CNT_W'(w);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/sma_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor moving average channels
// Valid/ready streams for raw sensor codes in and window means out.
// ----------------------------------------------------------------------------
interface sma_in_if import sma_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CODE_W-1:0] raw_code;

  modport source (output valid, output raw_code, input ready);
  modport sink   (input valid, input raw_code, output ready);
endinterface

interface sma_out_if import sma_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CODE_W-1:0] mean_code;
  logic                     corrupt;

  modport source (output valid, output mean_code, output corrupt, input ready);
  modport sink   (input valid, input mean_code, input corrupt, output ready);
endinterface
`default_nettype wire

/* hdl/sma_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* hdl/sma_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sma_div import sma_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [SUM_W-1:0] dividend_i,
  input  wire logic [CNT_W-1:0] divisor_i,
  output logic                  done_o,
  output logic      [SUM_W-1:0] quotient_o
);

  logic                  busy_q;
  logic [DIV_STEP_W-1:0] step_q;
  logic [CNT_W:0]        rem_q;
  logic [SUM_W-1:0]      quo_q;
  logic [CNT_W-1:0]      dvs_q;
  logic                  done_q;

  logic [CNT_W:0]        rem_sh;
  logic                  fits;

  assign rem_sh = {rem_q[CNT_W-1:0], quo_q[SUM_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= DIV_STEP_W'(SUM_W);
      end else if (busy_q) begin
        step_q <= step_q - DIV_STEP_W'(1);
        if (step_q == DIV_STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
      quo_q <= {quo_q[SUM_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

/* hdl/sensor_moving_average_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor moving average core
// Averages the last window_length valid temperature codes held in a ring.
// ----------------------------------------------------------------------------
// Path from the accepting edge to output valid: a corrupt (zero) code goes straight to
// the output load; a valid code with window W takes an index step (repeated on a wrap
// and after a shrink), W ring reads with one in flight, the serial divider, one load.
// One transaction is in work at a time, with input ready low meanwhile; input ready
// returns in the cycle after the output load, and the load waits while output stalls.
// Reset clears the ring (per-entry valid bits), write index and last mean; window 16.
// ----------------------------------------------------------------------------
module sensor_moving_average_core import sma_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  sma_in_if.sink                in_ch,
  sma_out_if.source             out_ch,
  input  wire logic             cfg_we_i,
  input  wire logic [WIN_W-1:0] cfg_wdata_i
);

  // Sequencer state and control.
  sma_state_e state_q, state_d;
  logic       in_fire;
  logic       out_free;
  logic       rd_en;
  logic       sum_done;
  logic       div_start;
  logic       div_done;

  // Window register and per-item working registers.
  logic [WIN_W-1:0]        cfg_q;
  logic [CNT_W-1:0]        win_q;
  logic [IDX_W-1:0]        wi_q;
  logic [CNT_W-1:0]        idx_q;
  logic [CNT_W-1:0]        addr_q;
  logic                    pend_q;
  logic                    pend_vld_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [RING_DEPTH-1:0]   valid_q;
  logic [CODE_W-1:0]       last_mean_q;
  logic [CODE_W-1:0]       res_mean_q;
  logic                    res_corrupt_q;

  // Output register.
  logic                    out_valid_q;
  logic [CODE_W-1:0]       out_mean_q;
  logic                    out_corrupt_q;

  // Datapath nets.
  logic                    ram_we;
  logic [CODE_W-1:0]       ram_rdata;
  logic [IDX_W-1:0]        raddr;
  logic [SUM_W-1:0]        sum_mag;
  logic [SUM_W-1:0]        quotient;
  logic [SUM_W-1:0]        mean_full;
  logic [SUM_W-1:0]        rd_ext;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_q || out_ch.ready;
  assign ram_we   = in_fire && (in_ch.raw_code != '0);

  // Read ring entries 0 .. window-1 in order; one is in flight after the last issue.
  assign rd_en    = (state_q == ST_SUM) && (addr_q < win_q);
  assign raddr    = addr_q[IDX_W-1:0];
  assign sum_done = (addr_q >= win_q) && !pend_q;

  // Divide the magnitude and restore the sign: truncation toward zero.
  assign sum_mag   = sum_q[SUM_W-1] ? (~sum_q + SUM_W'(1)) : sum_q;
  assign mean_full = sum_q[SUM_W-1] ? (~quotient + SUM_W'(1)) : quotient;
  // Entries never written since reset read as zero.
  assign rd_ext    = pend_vld_q ? {{(SUM_W-CODE_W){ram_rdata[CODE_W-1]}}, ram_rdata} : '0;

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (in_ch.raw_code == '0) ? ST_EMIT : ST_MOD;
        end
      end
      ST_MOD: begin
        if (idx_q < win_q) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        if (sum_done) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_q       <= WIN_RESET;
      valid_q     <= '0;
      wi_q        <= '0;
      last_mean_q <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (ram_we) begin
        valid_q[wi_q] <= 1'b1;
      end
      // Advance the write index once the wrap is resolved.
      if (state_q == ST_MOD && idx_q < win_q) begin
        wi_q <= idx_q[IDX_W-1:0];
      end
      pend_q <= rd_en;
      if (state_q == ST_DIV && div_done) begin
        last_mean_q <= mean_full[CODE_W-1:0];
      end
      // Load the output register when free, drop valid once taken.
      if (state_q == ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          res_mean_q    <= last_mean_q;
          res_corrupt_q <= (in_ch.raw_code == '0);
          idx_q         <= {1'b0, wi_q} + CNT_W'(1);
          win_q         <= eff_window(cfg_q);
        end
      end
      ST_MOD: begin
        // Wrap the next index; a shrunk window may take several subtractions.
        if (idx_q >= win_q) begin
          idx_q <= idx_q - win_q;
        end else begin
          addr_q <= '0;
          sum_q  <= '0;
        end
      end
      ST_SUM: begin
        if (rd_en) begin
          addr_q     <= addr_q + CNT_W'(1);
          pend_vld_q <= valid_q[raddr];
        end
        if (pend_q) begin
          sum_q <= sum_q + rd_ext;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_mean_q <= mean_full[CODE_W-1:0];
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_mean_q    <= res_mean_q;
          out_corrupt_q <= res_corrupt_q;
        end
      end
      default: begin
      end
    endcase
  end

  sma_ram #(
    .WIDTH (CODE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wi_q),
    .wdata_i (in_ch.raw_code),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  sma_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_mag),
    .divisor_i  (win_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign in_ch.ready      = (state_q == ST_IDLE);
  assign out_ch.valid     = out_valid_q;
  assign out_ch.mean_code = out_mean_q;
  assign out_ch.corrupt   = out_corrupt_q;

endmodule
`default_nettype wire
